/* hdl/cpp_pkg.sv */
// Shared constants and types for the camera pixel projection block.
`timescale 1ns / 1ps
package cpp_pkg;

  // Field widths
  localparam int unsigned CompW  = 20;   // one Q2.18 component
  localparam int unsigned AxisW  = 60;   // three packed components
  localparam int unsigned FixW   = 24;   // focal, aspect, area (Q8.16)
  localparam int unsigned ResW   = 13;   // resolution register
  localparam int unsigned CoordW = 21;   // pixel coordinate, Q13.8
  localparam int unsigned DensW  = 40;   // density, Q32.8
  localparam int unsigned CfgIdxW = 3;

  // 8*pi in Q5.28, rounded to nearest
  localparam logic [32:0] Pi8Q28 = 33'd6746518852;
  // Density saturates when the denominator does not exceed 8*pi << 10
  localparam logic [42:0] DensSatLim = {Pi8Q28, 10'b0};
  // Density dividend: the Q5.28 8*pi constant scaled by 2^50
  localparam logic [82:0] DensNum = {Pi8Q28, 50'b0};
  localparam logic [DensW-1:0] DensCap = '1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RIGHT   = 3'd0,
    CFG_UP      = 3'd1,
    CFG_FORWARD = 3'd2,
    CFG_FOCAL   = 3'd3,
    CFG_ASPECT  = 3'd4,
    CFG_WIDTH   = 3'd5,
    CFG_HEIGHT  = 3'd6,
    CFG_AREA    = 3'd7
  } cfg_reg_e;

endpackage

/* hdl/camera_pixel_projection.sv */
// Top level: pinhole camera projection of ray directions to pixel coordinates and density.
`timescale 1ns / 1ps
// One direction enters per clock while the pipe advances; it passes through four
// arithmetic stages (dot products, scaling, range checks with partial products,
// numerators and the cubed-depth denominator), then 40 stages of the density
// divider, whose one-bit-per-stage quotient sets the depth, with the two pixel
// coordinate dividers run alongside, then the output register. The whole pipe
// advances whenever the output register is empty or being taken, so a stall on
// the master side holds every stage in place. Configuration is taken at any time
// but must only change while no transaction is in flight.
module camera_pixel_projection #(
  parameter int unsigned MAX_RES = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [cpp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [cpp_pkg::AxisW-1:0]      cfg_data_i,
  // direction input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,   // dir_x, dir_y, dir_z, pad
  // projection output
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [87:0]                    m_axis_tdata,   // pixel_u, pixel_v, density, pad
  output logic                           m_axis_tuser    // in_view
);

  import cpp_pkg::*;

  localparam int unsigned DivStages = 40;
  localparam int unsigned UDenW     = 38;
  localparam int unsigned VDenW     = 46;
  localparam int unsigned DDenW     = 90;

  // Configuration registers
  logic [AxisW-1:0] right_q, up_q, fwd_q;
  logic [FixW-1:0]  focal_q, aspect_q, area_q;
  logic [ResW-1:0]  width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q  <= '0;
      up_q     <= '0;
      fwd_q    <= '0;
      focal_q  <= 24'd65536;
      aspect_q <= 24'd40960;
      width_q  <= 13'd320;
      height_q <= 13'd200;
      area_q   <= 24'd40960;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_RIGHT:   right_q  <= cfg_data_i;
        CFG_UP:      up_q     <= cfg_data_i;
        CFG_FORWARD: fwd_q    <= cfg_data_i;
        CFG_FOCAL:   focal_q  <= cfg_data_i[FixW-1:0];
        CFG_ASPECT:  aspect_q <= cfg_data_i[FixW-1:0];
        CFG_WIDTH:   width_q  <= cfg_data_i[ResW-1:0];
        CFG_HEIGHT:  height_q <= cfg_data_i[ResW-1:0];
        CFG_AREA:    area_q   <= cfg_data_i[FixW-1:0];
        default:     ;
      endcase
    end
  end

  // Derived configuration: aspect of zero acts as one LSB, resolution clamp
  logic [16:0]     max_res;
  logic [FixW-1:0] aspect_eff;
  logic [ResW-1:0] res_w, res_h;

  assign max_res    = 17'(MAX_RES);
  assign aspect_eff = (aspect_q == '0) ? FixW'(1) : aspect_q;
  assign res_w      = ({4'b0, width_q} > max_res) ? max_res[ResW-1:0] : width_q;
  assign res_h      = ({4'b0, height_q} > max_res) ? max_res[ResW-1:0] : height_q;

  // Pipe control
  logic en;
  logic out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Exact dot product in Q6.36, floored to Q6.18
  function automatic logic signed [23:0] dot_q18(logic [AxisW-1:0] ax, logic [AxisW-1:0] d);
    logic signed [39:0] p0, p1, p2;
    logic signed [41:0] s;
    p0 = $signed(ax[19:0])  * $signed(d[19:0]);
    p1 = $signed(ax[39:20]) * $signed(d[39:20]);
    p2 = $signed(ax[59:40]) * $signed(d[59:40]);
    s  = {{2{p0[39]}}, p0} + {{2{p1[39]}}, p1} + {{2{p2[39]}}, p2};
    return s[41:18];
  endfunction

  // Stage 1: dot products
  logic               v1_q;
  logic signed [23:0] dx1_q, dy1_q, dz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q <= dot_q18(right_q, s_axis_tdata[AxisW-1:0]);
      dy1_q <= dot_q18(up_q,    s_axis_tdata[AxisW-1:0]);
      dz1_q <= dot_q18(fwd_q,   s_axis_tdata[AxisW-1:0]);
    end
  end

  // Stage 2: focal scaling, depth products
  logic               v2_q, pos2_q;
  logic signed [48:0] nu2_q, nyf2_q;
  logic [21:0]        dz2_q;
  logic [45:0]        dv2_q, adz2_q;
  logic [43:0]        dzsq2_q;
  logic [21:0]        dz_u;

  assign dz_u = dz1_q[21:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos2_q  <= !dz1_q[23] && (dz1_q != '0);
      nu2_q   <= dx1_q * $signed({1'b0, focal_q});
      nyf2_q  <= dy1_q * $signed({1'b0, focal_q});
      dz2_q   <= dz_u;
      dv2_q   <= dz_u * aspect_eff;
      adz2_q  <= area_q * dz_u;
      dzsq2_q <= dz_u * dz_u;
    end
  end

  // Stage 3: window checks, shifted numerators, partial products of area*dz^3
  logic [48:0] nu_abs, nyf_abs;
  logic        ok_u, ok_v;
  logic [37:0] du2;
  logic signed [49:0] nu_off, nv_off;

  assign nu_abs  = nu2_q[48]  ? 49'(-nu2_q)  : 49'(nu2_q);
  assign nyf_abs = nyf2_q[48] ? 49'(-nyf2_q) : 49'(nyf2_q);
  assign du2     = {dz2_q, 16'b0};
  assign ok_u    = {nu_abs, 1'b0}  <= 50'(du2);
  assign ok_v    = {nyf_abs, 1'b0} <= 50'(dv2_q);
  assign nu_off  = 50'(nu2_q) + $signed({13'b0, dz2_q, 15'b0});
  assign nv_off  = $signed({nyf2_q, 1'b0}) + $signed({4'b0, dv2_q});

  logic        v3_q, acc3_q;
  logic [37:0] nu3_q, du3_q;
  logic [46:0] nv3_q;
  logic [45:0] dv3_q;
  logic [44:0] pll3_q, plh3_q, phl3_q, phh3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc3_q <= pos2_q && ok_u && ok_v;
      nu3_q  <= nu_off[37:0];
      nv3_q  <= nv_off[46:0];
      du3_q  <= du2;
      dv3_q  <= dv2_q;
      pll3_q <= adz2_q[22:0]  * dzsq2_q[21:0];
      plh3_q <= adz2_q[22:0]  * dzsq2_q[43:22];
      phl3_q <= adz2_q[45:23] * dzsq2_q[21:0];
      phh3_q <= adz2_q[45:23] * dzsq2_q[43:22];
    end
  end

  // Stage 4: resolution products, density denominator
  logic             v4_q, acc4_q;
  logic [50:0]      numu4_q;
  logic [59:0]      numv4_q;
  logic [UDenW-1:0] du4_q;
  logic [VDenW-1:0] dv4_q;
  logic [DDenW-1:0] den4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc4_q  <= acc3_q;
      numu4_q <= nu3_q * res_w;
      numv4_q <= nv3_q * res_h;
      du4_q   <= du3_q;
      dv4_q   <= dv3_q;
      den4_q  <= (DDenW'(phh3_q) << 45) + (DDenW'(plh3_q) << 22)
               + (DDenW'(phl3_q) << 23) + DDenW'(pll3_q);
    end
  end

  // Dividers
  logic [CoordW-1:0] quo_u, quo_v;
  logic [DensW-1:0]  quo_d;
  logic              sat4;

  assign sat4 = den4_q <= DDenW'(DensSatLim);

  cpp_div #(.DEN_W(UDenW), .Q_W(CoordW), .STAGES(DivStages)) u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({numu4_q, 8'b0}),
    .den_i (du4_q),
    .quo_o (quo_u)
  );

  cpp_div #(.DEN_W(VDenW), .Q_W(CoordW), .STAGES(DivStages)) u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({numv4_q, 7'b0}),
    .den_i (dv4_q),
    .quo_o (quo_v)
  );

  cpp_div #(.DEN_W(DDenW), .Q_W(DensW), .STAGES(DivStages)) u_div_d (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ((DDenW + DensW)'(DensNum)),
    .den_i (den4_q),
    .quo_o (quo_d)
  );

  // Valid and flags alongside the divider stages
  logic vld_q [DivStages];
  logic acc_q [DivStages];
  logic sat_q [DivStages];

  for (genvar i = 0; i < DivStages; i++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= (i == 0) ? v4_q : vld_q[(i == 0) ? 0 : i - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        acc_q[i] <= (i == 0) ? acc4_q : acc_q[(i == 0) ? 0 : i - 1];
        sat_q[i] <= (i == 0) ? sat4   : sat_q[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // Output register: rejected directions give zeros
  logic              in_view_q;
  logic [CoordW-1:0] pu_q, pv_q;
  logic [DensW-1:0]  dens_q;
  logic              acc_l, sat_l;

  assign acc_l = acc_q[DivStages-1];
  assign sat_l = sat_q[DivStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_view_q <= acc_l;
      pu_q      <= acc_l ? quo_u : '0;
      pv_q      <= acc_l ? quo_v : '0;
      dens_q    <= !acc_l ? '0 : (sat_l ? DensCap : quo_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = in_view_q;
  assign m_axis_tdata  = {6'b0, dens_q, pv_q, pu_q};

endmodule

/* hdl/cpp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, optional trailing delay stages.
`timescale 1ns / 1ps
module cpp_div #(
  parameter int unsigned DEN_W  = 46,
  parameter int unsigned Q_W    = 21,
  parameter int unsigned STAGES = 40
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DEN_W+Q_W-1:0]   num_i,   // must be below den_i << Q_W
  input  logic [DEN_W-1:0]       den_i,
  output logic [Q_W-1:0]         quo_o
);

  localparam int unsigned RemW = DEN_W + Q_W;

  logic [RemW-1:0]  rem_q [Q_W-1];
  logic [DEN_W-1:0] den_q [Q_W-1];
  logic [Q_W-1:0]   quo_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [Q_W-1:0] quo_in;

    if (i == 0) begin : g_q0
      assign quo_in = '0;
    end else begin : g_qn
      assign quo_in = quo_q[i-1];
    end

    if (i < Q_W) begin : g_bit
      localparam int unsigned Bit = Q_W - 1 - i;
      logic [RemW-1:0]  rem_in;
      logic [RemW-1:0]  dsh;
      logic [DEN_W-1:0] den_in;
      logic             ge;
      logic [Q_W-1:0]   quo_d;

      if (i == 0) begin : g_first
        assign rem_in = num_i;
        assign den_in = den_i;
      end else begin : g_next
        assign rem_in = rem_q[i-1];
        assign den_in = den_q[i-1];
      end

      // trial subtract of the shifted divisor
      always_comb begin
        dsh        = RemW'(den_in) << Bit;
        ge         = (rem_in >= dsh);
        quo_d      = quo_in;
        quo_d[Bit] = ge;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[i] <= quo_d;
        end
      end

      // remainder and divisor travel on while bits remain
      if (i < Q_W - 1) begin : g_keep
        logic [RemW-1:0] rem_d;
        assign rem_d = ge ? (rem_in - dsh) : rem_in;
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            rem_q[i] <= rem_d;
            den_q[i] <= den_in;
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          quo_q[i] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[STAGES-1];

endmodule
